@@ sv/sot_pkg.sv @@
package sot_pkg;

    localparam int COORD_WIDTH = 20;
    localparam int RAD_W       = COORD_WIDTH - 1;
    localparam int DIFF_W      = COORD_WIDTH + 1;
    localparam int HIT_W       = COORD_WIDTH + 1;
    localparam int SQ_W        = 2 * COORD_WIDTH;
    localparam int SUM_W       = SQ_W + 1;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic        [RAD_W-1:0]       t_radius;
    typedef logic signed [DIFF_W-1:0]      t_diff;
    typedef logic signed [HIT_W-1:0]       t_hit;
    typedef logic        [COORD_WIDTH-1:0] t_rsum;
    typedef logic        [SQ_W-1:0]        t_square;

    typedef enum logic [2:0] {
        FN_BOX_BOX       = 3'd0,
        FN_CIRCLE_CIRCLE = 3'd1,
        FN_BOX_CIRCLE    = 3'd2,
        FN_POINT_BOX     = 3'd3,
        FN_POINT_CIRCLE  = 3'd4
    } t_func;

    typedef struct packed {
        t_func  func;
        logic   pre_hit;
        logic   corner;
        t_diff  ex0;
        t_diff  ex1;
        t_diff  ey0;
        t_diff  ey1;
        t_rsum  rad;
        t_diff  ax;
        t_diff  bx;
        t_diff  ay;
        t_diff  by;
    } t_stage1;

    typedef struct packed {
        t_func   func;
        logic    pre_hit;
        logic    corner;
        t_square sqx0;
        t_square sqx1;
        t_square sqy0;
        t_square sqy1;
        t_square r2;
        t_hit    hx;
        t_hit    hy;
    } t_stage2;

    function automatic t_diff sext(input t_coord v);
        return {v[COORD_WIDTH-1], v};
    endfunction

    function automatic t_diff dmax(input t_diff a, input t_diff b);
        return (a > b) ? a : b;
    endfunction

    function automatic t_diff dmin(input t_diff a, input t_diff b);
        return (a < b) ? a : b;
    endfunction

endpackage

@@ sv/sot_prep.sv @@
module sot_prep
    import sot_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_down_ready,
    output logic    o_ready,
    output logic    o_valid,
    input  t_func   i_func,
    input  t_coord  i_src_x0,
    input  t_coord  i_src_y0,
    input  t_coord  i_src_x1,
    input  t_coord  i_src_y1,
    input  t_radius i_src_radius,
    input  t_coord  i_dst_x0,
    input  t_coord  i_dst_y0,
    input  t_coord  i_dst_x1,
    input  t_coord  i_dst_y1,
    input  t_radius i_dst_radius,
    output t_stage1 o_data
);

    logic    r_valid;
    t_stage1 r_data;
    t_stage1 n_data;

    t_diff sx0, sy0, sx1, sy1, dx0, dy0, ri;
    logic  bb_hit, pb_hit, in_span, grown_hit;

    assign o_ready = !r_valid || i_down_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        sx0 = sext(i_src_x0);
        sy0 = sext(i_src_y0);
        sx1 = sext(i_src_x1);
        sy1 = sext(i_src_y1);
        dx0 = sext(i_dst_x0);
        dy0 = sext(i_dst_y0);
        ri  = t_diff'({2'b00, i_dst_radius});

        bb_hit = !(i_src_x0 > i_dst_x1 || i_src_y0 > i_dst_y1 ||
                   i_src_x1 < i_dst_x0 || i_src_y1 < i_dst_y0);
        pb_hit = !(i_dst_x0 > i_src_x0 || i_dst_y0 > i_src_y0 ||
                   i_dst_x1 < i_src_x0 || i_dst_y1 < i_src_y0);
        in_span = (i_src_x0 <= i_dst_x0 && i_dst_x0 <= i_src_x1) ||
                  (i_src_y0 <= i_dst_y0 && i_dst_y0 <= i_src_y1);
        grown_hit = !(sx0 - ri > dx0 || sy0 - ri > dy0 ||
                      sx1 + ri < dx0 || sy1 + ri < dy0);

        n_data.func    = i_func;
        n_data.pre_hit = 1'b0;
        n_data.corner  = 1'b0;
        n_data.ex0     = sx0 - dx0;
        n_data.ex1     = sx1 - dx0;
        n_data.ey0     = sy0 - dy0;
        n_data.ey1     = sy1 - dy0;
        n_data.rad     = {1'b0, i_dst_radius};
        n_data.ax      = sx0;
        n_data.bx      = sx0;
        n_data.ay      = sy0;
        n_data.by      = sy0;

        unique case (i_func)
            FN_BOX_BOX: begin
                n_data.pre_hit = bb_hit;
                n_data.ax      = sext(i_src_x0 > i_dst_x0 ? i_src_x0 : i_dst_x0);
                n_data.bx      = sext(i_src_x1 < i_dst_x1 ? i_src_x1 : i_dst_x1);
                n_data.ay      = sext(i_src_y0 > i_dst_y0 ? i_src_y0 : i_dst_y0);
                n_data.by      = sext(i_src_y1 < i_dst_y1 ? i_src_y1 : i_dst_y1);
            end
            FN_CIRCLE_CIRCLE: begin
                n_data.rad = t_rsum'({1'b0, i_src_radius}) + t_rsum'({1'b0, i_dst_radius});
                n_data.bx  = dx0;
                n_data.by  = dy0;
            end
            FN_BOX_CIRCLE: begin
                n_data.pre_hit = grown_hit;
                n_data.corner  = !in_span;
                n_data.ax      = dmax(sx0, dx0 - ri);
                n_data.bx      = dmin(sx1, dx0 + ri);
                n_data.ay      = dmax(sy0, dy0 - ri);
                n_data.by      = dmin(sy1, dy0 + ri);
            end
            FN_POINT_BOX: begin
                n_data.pre_hit = pb_hit;
            end
            FN_POINT_CIRCLE: begin
                n_data.pre_hit = 1'b0;
            end
            default: begin
                n_data.pre_hit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

@@ sv/sot_square.sv @@
module sot_square
    import sot_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_down_ready,
    output logic    o_ready,
    output logic    o_valid,
    input  t_stage1 i_data,
    output t_stage2 o_data
);

    logic    r_valid;
    t_stage2 r_data;
    t_stage2 n_data;

    logic signed [2*DIFF_W-1:0] px0, px1, py0, py1;
    logic        [SQ_W-1:0]     pr;

    assign o_ready = !r_valid || i_down_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        px0 = i_data.ex0 * i_data.ex0;
        px1 = i_data.ex1 * i_data.ex1;
        py0 = i_data.ey0 * i_data.ey0;
        py1 = i_data.ey1 * i_data.ey1;
        pr  = i_data.rad * i_data.rad;

        n_data.func    = i_data.func;
        n_data.pre_hit = i_data.pre_hit;
        n_data.corner  = i_data.corner;
        n_data.sqx0    = px0[SQ_W-1:0];
        n_data.sqx1    = px1[SQ_W-1:0];
        n_data.sqy0    = py0[SQ_W-1:0];
        n_data.sqy1    = py1[SQ_W-1:0];
        n_data.r2      = pr;
        n_data.hx      = i_data.ax + i_data.bx;
        n_data.hy      = i_data.ay + i_data.by;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

@@ sv/sot_judge.sv @@
module sot_judge
    import sot_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_down_ready,
    output logic    o_ready,
    output logic    o_valid,
    input  t_stage2 i_data,
    output logic    o_hit,
    output t_hit    o_hit_x,
    output t_hit    o_hit_y
);

    logic r_valid;
    logic r_hit;
    t_hit r_hit_x;
    t_hit r_hit_y;
    logic n_hit;
    t_hit n_hit_x;
    t_hit n_hit_y;

    logic [SUM_W-1:0] s00, s10, s01, s11, r2e;
    logic             w00, w10, w01, w11;

    assign o_ready = !r_valid || i_down_ready;
    assign o_valid = r_valid;
    assign o_hit   = r_hit;
    assign o_hit_x = r_hit_x;
    assign o_hit_y = r_hit_y;

    always_comb begin
        s00 = {1'b0, i_data.sqx0} + {1'b0, i_data.sqy0};
        s10 = {1'b0, i_data.sqx1} + {1'b0, i_data.sqy0};
        s01 = {1'b0, i_data.sqx0} + {1'b0, i_data.sqy1};
        s11 = {1'b0, i_data.sqx1} + {1'b0, i_data.sqy1};
        r2e = {1'b0, i_data.r2};
        w00 = s00 <= r2e;
        w10 = s10 <= r2e;
        w01 = s01 <= r2e;
        w11 = s11 <= r2e;

        unique case (i_data.func)
            FN_BOX_BOX:       n_hit = i_data.pre_hit;
            FN_CIRCLE_CIRCLE: n_hit = w00;
            FN_BOX_CIRCLE:    n_hit = i_data.corner ? (w00 || w10 || w01 || w11)
                                                    : i_data.pre_hit;
            FN_POINT_BOX:     n_hit = i_data.pre_hit;
            FN_POINT_CIRCLE:  n_hit = w00;
            default:          n_hit = 1'b0;
        endcase

        if (n_hit || i_data.func == FN_CIRCLE_CIRCLE) begin
            n_hit_x = i_data.hx;
            n_hit_y = i_data.hy;
        end else begin
            n_hit_x = '0;
            n_hit_y = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_hit   <= n_hit;
            r_hit_x <= n_hit_x;
            r_hit_y <= n_hit_y;
        end
    end

endmodule

@@ sv/shape_overlap_tester.sv @@
// Tests one pair of 2D shapes per beat (box-box, circle-circle, box-circle,
// point-box or point-circle) in signed Q16.4 coordinates and returns a hit
// flag with a hit point in Q16.5. The block accepts one beat every cycle
// while input stall is low and holds three register stages: edge differences
// and compares, the squaring multipliers, and the distance sum, compare and
// result select. An output stall holds results in place while empty stages
// ahead of it keep filling, so input stall rises only once all three stages
// hold a beat.
module shape_overlap_tester
    import sot_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    input  logic [2:0] i_func,
    input  t_coord  i_src_x0,
    input  t_coord  i_src_y0,
    input  t_coord  i_src_x1,
    input  t_coord  i_src_y1,
    input  t_radius i_src_radius,
    input  t_coord  i_dst_x0,
    input  t_coord  i_dst_y0,
    input  t_coord  i_dst_x1,
    input  t_coord  i_dst_y1,
    input  t_radius i_dst_radius,
    output logic    o_valid,
    input  logic    i_stall,
    output logic    o_hit,
    output t_hit    o_hit_x,
    output t_hit    o_hit_y
);

    logic    ready1, ready2, ready3;
    logic    valid1, valid2;
    t_stage1 data1;
    t_stage2 data2;

    assign o_stall = !ready1;

    sot_prep u_prep (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_down_ready (ready2),
        .o_ready      (ready1),
        .o_valid      (valid1),
        .i_func       (t_func'(i_func)),
        .i_src_x0     (i_src_x0),
        .i_src_y0     (i_src_y0),
        .i_src_x1     (i_src_x1),
        .i_src_y1     (i_src_y1),
        .i_src_radius (i_src_radius),
        .i_dst_x0     (i_dst_x0),
        .i_dst_y0     (i_dst_y0),
        .i_dst_x1     (i_dst_x1),
        .i_dst_y1     (i_dst_y1),
        .i_dst_radius (i_dst_radius),
        .o_data       (data1)
    );

    sot_square u_square (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (valid1),
        .i_down_ready (ready3),
        .o_ready      (ready2),
        .o_valid      (valid2),
        .i_data       (data1),
        .o_data       (data2)
    );

    sot_judge u_judge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (valid2),
        .i_down_ready (!i_stall),
        .o_ready      (ready3),
        .o_valid      (o_valid),
        .i_data       (data2),
        .o_hit        (o_hit),
        .o_hit_x      (o_hit_x),
        .o_hit_y      (o_hit_y)
    );

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (valid1 && valid2 && o_valid))
        else $error("Input stall raised while a pipeline stage is empty.");

    a_empty_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && !valid1 && !valid2 && !o_valid) |=> ##2 o_valid)
        else $error("Beat entering an empty pipeline did not reach the output.");

    a_advance_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (valid1 && !i_stall) |=> valid2)
        else $error("Stage one beat did not advance with the output free.");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("Output valid set after reset.");

endmodule

@@ bench/overlap_checker.sv @@
module overlap_checker
    import sot_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [2:0] i_func,
    input  t_coord     i_src_x0,
    input  t_coord     i_src_y0,
    input  t_coord     i_src_x1,
    input  t_coord     i_src_y1,
    input  t_radius    i_src_radius,
    input  t_coord     i_dst_x0,
    input  t_coord     i_dst_y0,
    input  t_coord     i_dst_x1,
    input  t_coord     i_dst_y1,
    input  t_radius    i_dst_radius,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic       i_hit,
    input  t_hit       i_hit_x,
    input  t_hit       i_hit_y,
    output int         o_mismatches,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic hit;
        t_hit hx;
        t_hit hy;
    } t_answer;

    t_answer awaited_answers[$];
    t_answer oldest;

    function automatic longint lmax(input longint a, input longint b);
        return (a > b) ? a : b;
    endfunction

    function automatic longint lmin(input longint a, input longint b);
        return (a < b) ? a : b;
    endfunction

    // Squared distance test; a sum that wraps counts as out of reach.
    function automatic logic in_reach(input longint ex, input longint ey,
                                      input longint unsigned r);
        longint unsigned ax;
        longint unsigned ay;
        longint unsigned total;
        ax = (ex < 0) ? -ex : ex;
        ay = (ey < 0) ? -ey : ey;
        ax = ax * ax;
        ay = ay * ay;
        total = ax + ay;
        if (total < ax)
            return 1'b0;
        return total <= r * r;
    endfunction

    function automatic t_answer overlap_answer(
        input logic [2:0] func,
        input t_coord src_x0, input t_coord src_y0,
        input t_coord src_x1, input t_coord src_y1, input t_radius src_r,
        input t_coord dst_x0, input t_coord dst_y0,
        input t_coord dst_x1, input t_coord dst_y1, input t_radius dst_r
    );
        longint sx0, sy0, sx1, sy1, dx0, dy0, dx1, dy1, rs, rd;
        logic touch;
        longint hx, hy;
        t_answer ans;
        sx0 = src_x0;
        sy0 = src_y0;
        sx1 = src_x1;
        sy1 = src_y1;
        dx0 = dst_x0;
        dy0 = dst_y0;
        dx1 = dst_x1;
        dy1 = dst_y1;
        rs = longint'(src_r);
        rd = longint'(dst_r);
        touch = 1'b0;
        hx = 0;
        hy = 0;
        case (func)
            FN_BOX_BOX: begin
                if (!(sx0 > dx1 || sy0 > dy1 || sx1 < dx0 || sy1 < dy0)) begin
                    touch = 1'b1;
                    hx = lmax(sx0, dx0) + lmin(sx1, dx1);
                    hy = lmax(sy0, dy0) + lmin(sy1, dy1);
                end
            end
            FN_CIRCLE_CIRCLE: begin
                touch = in_reach(dx0 - sx0, dy0 - sy0, rs + rd);
                hx = sx0 + dx0;
                hy = sy0 + dy0;
            end
            FN_BOX_CIRCLE: begin
                if ((sx0 <= dx0 && dx0 <= sx1) || (sy0 <= dy0 && dy0 <= sy1)) begin
                    touch = !(sx0 - rd > dx0 || sy0 - rd > dy0 ||
                              sx1 + rd < dx0 || sy1 + rd < dy0);
                end else begin
                    touch = in_reach(sx0 - dx0, sy0 - dy0, rd) ||
                            in_reach(sx1 - dx0, sy0 - dy0, rd) ||
                            in_reach(sx0 - dx0, sy1 - dy0, rd) ||
                            in_reach(sx1 - dx0, sy1 - dy0, rd);
                end
                if (touch) begin
                    hx = lmax(sx0, dx0 - rd) + lmin(sx1, dx0 + rd);
                    hy = lmax(sy0, dy0 - rd) + lmin(sy1, dy0 + rd);
                end
            end
            FN_POINT_BOX: begin
                if (!(dx0 > sx0 || dy0 > sy0 || dx1 < sx0 || dy1 < sy0)) begin
                    touch = 1'b1;
                    hx = sx0 * 2;
                    hy = sy0 * 2;
                end
            end
            FN_POINT_CIRCLE: begin
                if (in_reach(sx0 - dx0, sy0 - dy0, rd)) begin
                    touch = 1'b1;
                    hx = sx0 * 2;
                    hy = sy0 * 2;
                end
            end
            default: begin
            end
        endcase
        ans.hit = touch;
        ans.hx = hx[HIT_W-1:0];
        ans.hy = hy[HIT_W-1:0];
        return ans;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_out_valid && !i_out_stall) begin
                if (awaited_answers.size() == 0) begin
                    if (o_mismatches < 10)
                        $display("%0t: result beat with nothing pending: hit %0b x %0d y %0d",
                                 $realtime, i_hit, i_hit_x, i_hit_y);
                    o_mismatches <= o_mismatches + 1;
                end else begin
                    oldest = awaited_answers.pop_front();
                    if (i_hit !== oldest.hit || i_hit_x !== oldest.hx ||
                        i_hit_y !== oldest.hy) begin
                        if (o_mismatches < 10)
                            $display({"%0t: mismatch: hit %0b/%0b x %0d/%0d y %0d/%0d",
                                      " (expected/actual)"},
                                     $realtime, oldest.hit, i_hit, oldest.hx, i_hit_x,
                                     oldest.hy, i_hit_y);
                        o_mismatches <= o_mismatches + 1;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                awaited_answers.insert(awaited_answers.size(), overlap_answer(
                    i_func, i_src_x0, i_src_y0, i_src_x1, i_src_y1, i_src_radius,
                    i_dst_x0, i_dst_y0, i_dst_x1, i_dst_y1, i_dst_radius));
            o_pending <= awaited_answers.size();
        end
    end

endmodule

@@ bench/tb_top.sv @@
module tb_top
    import sot_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     RANDOM_PAIRS = 1325;
    localparam int     CALM_TAIL    = 150;
    localparam int     IDLE_LIMIT   = 400;
    localparam t_coord C_MAX        = 20'sd524287;
    localparam t_coord C_MIN        = -20'sd524288;
    localparam t_radius R_MAX       = 19'd524287;

    typedef struct {
        logic [2:0] func;
        t_coord     sx0, sy0, sx1, sy1;
        t_radius    sr;
        t_coord     dx0, dy0, dx1, dy1;
        t_radius    dr;
    } t_pair;

    logic    clk = 1'b0;
    logic    rst_n;
    logic    in_valid;
    logic    in_stall;
    logic [2:0] func;
    t_coord  src_x0, src_y0, src_x1, src_y1;
    t_radius src_radius;
    t_coord  dst_x0, dst_y0, dst_x1, dst_y1;
    t_radius dst_radius;
    logic    out_valid;
    logic    out_stall;
    logic    hit;
    t_hit    hit_x, hit_y;
    int      mismatches;
    int      pending;
    int      idle_cycles = 0;
    logic    calm = 1'b0;

    always #1 clk = ~clk;

    shape_overlap_tester dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_stall(in_stall),
        .i_func(func),
        .i_src_x0(src_x0), .i_src_y0(src_y0), .i_src_x1(src_x1), .i_src_y1(src_y1),
        .i_src_radius(src_radius),
        .i_dst_x0(dst_x0), .i_dst_y0(dst_y0), .i_dst_x1(dst_x1), .i_dst_y1(dst_y1),
        .i_dst_radius(dst_radius),
        .o_valid(out_valid), .i_stall(out_stall),
        .o_hit(hit), .o_hit_x(hit_x), .o_hit_y(hit_y)
    );

    overlap_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_func(func),
        .i_src_x0(src_x0), .i_src_y0(src_y0), .i_src_x1(src_x1), .i_src_y1(src_y1),
        .i_src_radius(src_radius),
        .i_dst_x0(dst_x0), .i_dst_y0(dst_y0), .i_dst_x1(dst_x1), .i_dst_y1(dst_y1),
        .i_dst_radius(dst_radius),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_hit(hit), .i_hit_x(hit_x), .i_hit_y(hit_y),
        .o_mismatches(mismatches), .o_pending(pending)
    );

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Result-side stall comes in bursts, with quiet stretches between them.
    initial begin
        int unsigned burst;
        int unsigned mode;
        out_stall = 1'b0;
        forever begin
            if (calm) begin
                @(negedge clk);
                out_stall = 1'b0;
            end else begin
                burst = $urandom_range(1, 11);
                mode = $urandom_range(0, 9);
                if (mode == 0)
                    burst = 60;
                repeat (burst) begin
                    @(negedge clk);
                    out_stall = (mode >= 6) && !calm;
                end
            end
        end
    end

    function automatic t_pair pair_of(
        input logic [2:0] f,
        input t_coord sx0, input t_coord sy0, input t_coord sx1, input t_coord sy1,
        input t_radius sr,
        input t_coord dx0, input t_coord dy0, input t_coord dx1, input t_coord dy1,
        input t_radius dr
    );
        t_pair p;
        p.func = f;
        p.sx0 = sx0;
        p.sy0 = sy0;
        p.sx1 = sx1;
        p.sy1 = sy1;
        p.sr = sr;
        p.dx0 = dx0;
        p.dy0 = dy0;
        p.dx1 = dx1;
        p.dy1 = dy1;
        p.dr = dr;
        return p;
    endfunction

    function automatic t_coord nudge(input t_coord from, input int unsigned bits);
        int off;
        off = int'($urandom_range(0, (1 << bits) - 1)) - ((1 << bits) >> 1);
        return t_coord'(int'(from) + off);
    endfunction

    function automatic t_coord stretch(input t_coord from, input int unsigned bits);
        return t_coord'(int'(from) + int'($urandom_range(0, (1 << bits) - 1)));
    endfunction

    // Shapes are mostly placed around a shared spot so that hits and near
    // misses are both common; the rest is raw noise across every bit.
    function automatic t_pair random_pair();
        t_pair p;
        int unsigned roll;
        int unsigned span;
        int unsigned sz;
        t_coord hub_x;
        t_coord hub_y;
        roll = $urandom_range(0, 99);
        if (roll < 15)
            return pair_of(3'($urandom), t_coord'($urandom), t_coord'($urandom),
                           t_coord'($urandom), t_coord'($urandom), t_radius'($urandom),
                           t_coord'($urandom), t_coord'($urandom), t_coord'($urandom),
                           t_coord'($urandom), t_radius'($urandom));
        p.func = (roll < 20) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
        span = $urandom_range(1, 19);
        sz = $urandom_range(0, span);
        hub_x = t_coord'($urandom);
        hub_y = t_coord'($urandom);
        p.sx0 = nudge(hub_x, span);
        p.sy0 = nudge(hub_y, span);
        p.sx1 = stretch(p.sx0, sz);
        p.sy1 = stretch(p.sy0, sz);
        p.dx0 = nudge(hub_x, span);
        p.dy0 = nudge(hub_y, span);
        p.dx1 = stretch(p.dx0, sz);
        p.dy1 = stretch(p.dy0, sz);
        p.sr = t_radius'($urandom_range(0, (1 << sz) - 1));
        p.dr = t_radius'($urandom_range(0, (1 << sz) - 1));
        if ($urandom_range(0, 9) == 0) begin
            p.sx1 = nudge(p.sx0, sz + 1);
            p.dy1 = nudge(p.dy0, sz + 1);
        end
        return p;
    endfunction

    task automatic send_pair(input t_pair p);
        @(negedge clk);
        func = p.func;
        src_x0 = p.sx0;
        src_y0 = p.sy0;
        src_x1 = p.sx1;
        src_y1 = p.sy1;
        src_radius = p.sr;
        dst_x0 = p.dx0;
        dst_y0 = p.dy0;
        dst_x1 = p.dx1;
        dst_y1 = p.dy1;
        dst_radius = p.dr;
        in_valid = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic hold_off(input int unsigned cycles);
        repeat (cycles) begin
            @(negedge clk);
            in_valid = 1'b0;
        end
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        func = '0;
        src_x0 = '0;
        src_y0 = '0;
        src_x1 = '0;
        src_y1 = '0;
        src_radius = '0;
        dst_x0 = '0;
        dst_y0 = '0;
        dst_x1 = '0;
        dst_y1 = '0;
        dst_radius = '0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        send_pair(pair_of(FN_BOX_BOX, 0, 0, 160, 160, 0, 80, 80, 320, 320, 0));
        send_pair(pair_of(FN_BOX_BOX, 0, 0, 16, 16, 5, 16, 16, 32, 32, 9));
        send_pair(pair_of(FN_BOX_BOX, 100, 0, 200, 50, 0, 0, 0, 99, 50, 0));
        send_pair(pair_of(FN_BOX_BOX, 0, 100, 50, 200, 0, 0, 0, 50, 99, 0));
        send_pair(pair_of(FN_BOX_BOX, C_MIN, C_MIN, C_MAX, C_MAX, R_MAX,
                          C_MIN, C_MIN, C_MAX, C_MAX, R_MAX));
        send_pair(pair_of(FN_BOX_BOX, 200, 200, 0, 0, 0, 0, 0, 300, 300, 0));
        send_pair(pair_of(FN_CIRCLE_CIRCLE, 0, 0, 7, 7, 32, 48, 64, 3, 3, 48));
        send_pair(pair_of(FN_CIRCLE_CIRCLE, 0, 0, 0, 0, 32, 49, 64, 0, 0, 48));
        send_pair(pair_of(FN_CIRCLE_CIRCLE, C_MIN, C_MIN, 0, 0, R_MAX,
                          C_MAX, C_MAX, 0, 0, R_MAX));
        send_pair(pair_of(FN_CIRCLE_CIRCLE, -33, 17, 0, 0, 0, -33, 17, 0, 0, 0));
        send_pair(pair_of(FN_BOX_CIRCLE, 0, 0, 160, 160, 11, 80, 200, 0, 0, 48));
        send_pair(pair_of(FN_BOX_CIRCLE, 0, 0, 160, 160, 0, 80, 210, 0, 0, 48));
        send_pair(pair_of(FN_BOX_CIRCLE, 0, 0, 160, 160, 0, 190, 200, 0, 0, 50));
        send_pair(pair_of(FN_BOX_CIRCLE, 0, 0, 160, 160, 0, 190, 201, 0, 0, 50));
        send_pair(pair_of(FN_BOX_CIRCLE, 0, 0, 160, 160, 0, 80, 80, 0, 0, 0));
        send_pair(pair_of(FN_BOX_CIRCLE, C_MIN, C_MIN, C_MAX, C_MAX, 0,
                          C_MAX, C_MAX, 0, 0, R_MAX));
        send_pair(pair_of(FN_POINT_BOX, 50, 50, 0, 0, 0, 0, 0, 100, 100, 0));
        send_pair(pair_of(FN_POINT_BOX, 100, 0, 0, 0, 0, 0, 0, 100, 100, 0));
        send_pair(pair_of(FN_POINT_BOX, 101, 0, 0, 0, 0, 0, 0, 100, 100, 0));
        send_pair(pair_of(FN_POINT_BOX, C_MIN, C_MAX, 0, 0, 0, C_MIN, C_MIN, C_MAX, C_MAX, 0));
        send_pair(pair_of(FN_POINT_CIRCLE, 30, 40, 0, 0, 0, 0, 0, 0, 0, 50));
        send_pair(pair_of(FN_POINT_CIRCLE, 30, 41, 0, 0, 0, 0, 0, 0, 0, 50));
        send_pair(pair_of(FN_POINT_CIRCLE, C_MAX, C_MAX, 0, 0, 0, C_MIN, C_MIN, 0, 0, R_MAX));
        send_pair(pair_of(3'd5, 0, 0, 160, 160, 32, 80, 80, 320, 320, 48));
        send_pair(pair_of(3'd6, 30, 40, 0, 0, 0, 0, 0, 0, 0, 50));
        send_pair(pair_of(3'd7, 50, 50, 0, 0, 0, 0, 0, 100, 100, 0));
        drain_results();

        for (int n = 0; n < RANDOM_PAIRS; n++) begin
            if (n == RANDOM_PAIRS - CALM_TAIL)
                calm = 1'b1;
            if (n == RANDOM_PAIRS / 2)
                drain_results();
            if (!calm && (n / 100) % 3 != 2 && $urandom_range(0, 4) == 0)
                hold_off($urandom_range(1, 11));
            send_pair(random_pair());
        end
        drain_results();
        repeat (8) @(negedge clk);

        if (mismatches == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
